### design/rtcacc_pkg.sv
package rtcacc_pkg;

  localparam int unsigned TICK_W  = 32;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned FRAC_W  = 15;
  localparam int unsigned PROD_W  = 25;
  localparam int unsigned MS_W    = 10;
  localparam int unsigned MICRO_W = 20;
  localparam int unsigned DIGIT_W = 8;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd15;
  localparam logic [MS_W-1:0]    US_PER_MS   = 10'd1000;

  typedef logic [MS_W-1:0] ms_t;

endpackage

### design/rtc_tick_to_seconds_micros_accumulator.sv
// An accepted request runs the sub-second step (ST_MIC0, ST_MIC1), then the
// seconds add and the x1000 milli product byte-serially in ST_SEC, then ST_DONE.
// A new request is taken only in ST_IDLE, after the previous one leaves ST_DONE;
// it is taken while the previous result waits on out_ready.
// Reset (rst_n low, synchronous): seconds and microseconds clear to zero,
// tick_shift returns to 15, no result is pending.
module rtc_tick_to_seconds_micros_accumulator
  import rtcacc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SHIFT_W-1:0]  cfg_tick_shift,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TICK_W-1:0]   in_tick_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TICK_W-1:0]   out_total_seconds,
  output logic [MICRO_W-1:0]  out_micro_part,
  output logic [TICK_W-1:0]   out_milli_ticks,
  output logic [MS_W-1:0]     out_sub_milli_micros
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MIC0 = 3'd1;
  localparam logic [2:0] ST_MIC1 = 3'd2;
  localparam logic [2:0] ST_SEC  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          digit_r, digit_nxt;
  logic [SHIFT_W-1:0]  shift_r;
  logic [TICK_W-1:0]   sec_r, sec_nxt;
  logic [TICK_W-1:0]   add_r, add_nxt;
  logic [TICK_W-1:0]   mil_r, mil_nxt;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;
  logic [FRAC_W-1:0]   rem_r, rem_nxt;
  ms_t                 ms_r, ms_nxt;
  ms_t                 ms_acc_r, ms_acc_nxt;
  ms_t                 us_acc_r, us_acc_nxt;
  ms_t                 mc_r, mc_nxt;
  logic                carry_r, carry_nxt;
  logic                out_valid_r;
  logic [TICK_W-1:0]   o_sec_r, o_mil_r;
  logic [MICRO_W-1:0]  o_micro_r;
  ms_t                 o_sub_r;

  logic [FRAC_W-1:0]   mask;
  logic [PROD_W-1:0]   p1, p2;
  ms_t                 us_step;
  logic [MS_W:0]       us_sum, ms_sum;
  logic                cu;
  logic [DIGIT_W:0]    dsum;
  logic [17:0]         mprod;
  logic                accept, load_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    mask     = FRAC_W'((16'h1 << shift_r) - 16'h1);
    p1       = PROD_W'(frac_r) * PROD_W'(US_PER_MS);
    p2       = PROD_W'(rem_r) * PROD_W'(US_PER_MS);
    us_step  = MS_W'(p2 >> shift_r);
    us_sum   = {1'b0, us_acc_r} + {1'b0, us_step};
    cu       = (us_sum >= {1'b0, US_PER_MS});
    ms_sum   = {1'b0, ms_acc_r} + {1'b0, ms_r} + {{MS_W{1'b0}}, cu};
    dsum     = {1'b0, sec_r[DIGIT_W-1:0]} + {1'b0, add_r[DIGIT_W-1:0]}
             + {{DIGIT_W{1'b0}}, carry_r};
    mprod    = 18'(dsum[DIGIT_W-1:0]) * 18'(US_PER_MS) + 18'(mc_r);

    state_nxt  = state_r;
    digit_nxt  = digit_r;
    sec_nxt    = sec_r;
    add_nxt    = add_r;
    mil_nxt    = mil_r;
    frac_nxt   = frac_r;
    rem_nxt    = rem_r;
    ms_nxt     = ms_r;
    ms_acc_nxt = ms_acc_r;
    us_acc_nxt = us_acc_r;
    mc_nxt     = mc_r;
    carry_nxt  = carry_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          add_nxt   = in_tick_count >> shift_r;
          frac_nxt  = in_tick_count[FRAC_W-1:0] & mask;
          state_nxt = ST_MIC0;
        end
      end
      ST_MIC0: begin
        ms_nxt    = MS_W'(p1 >> shift_r);
        rem_nxt   = p1[FRAC_W-1:0] & mask;
        state_nxt = ST_MIC1;
      end
      ST_MIC1: begin
        us_acc_nxt = cu ? MS_W'(us_sum - {1'b0, US_PER_MS}) : us_sum[MS_W-1:0];
        carry_nxt  = (ms_sum >= {1'b0, US_PER_MS});
        ms_acc_nxt = carry_nxt ? MS_W'(ms_sum - {1'b0, US_PER_MS}) : ms_sum[MS_W-1:0];
        mc_nxt     = ms_acc_nxt;
        digit_nxt  = 2'd0;
        state_nxt  = ST_SEC;
      end
      ST_SEC: begin
        sec_nxt   = {dsum[DIGIT_W-1:0], sec_r[TICK_W-1:DIGIT_W]};
        add_nxt   = {{DIGIT_W{1'b0}}, add_r[TICK_W-1:DIGIT_W]};
        mil_nxt   = {mprod[DIGIT_W-1:0], mil_r[TICK_W-1:DIGIT_W]};
        mc_nxt    = MS_W'(mprod >> DIGIT_W);
        carry_nxt = dsum[DIGIT_W];
        digit_nxt = digit_r + 2'd1;
        if (digit_r == 2'd3) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      digit_r     <= 2'd0;
      shift_r     <= SHIFT_RESET;
      sec_r       <= '0;
      ms_acc_r    <= '0;
      us_acc_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      digit_r  <= digit_nxt;
      sec_r    <= sec_nxt;
      ms_acc_r <= ms_acc_nxt;
      us_acc_r <= us_acc_nxt;
      if (cfg_valid) begin
        shift_r <= cfg_tick_shift;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    add_r   <= add_nxt;
    mil_r   <= mil_nxt;
    frac_r  <= frac_nxt;
    rem_r   <= rem_nxt;
    ms_r    <= ms_nxt;
    mc_r    <= mc_nxt;
    carry_r <= carry_nxt;
    if (load_out) begin
      o_sec_r   <= sec_r;
      o_mil_r   <= mil_r;
      o_micro_r <= MICRO_W'(ms_acc_r) * MICRO_W'(US_PER_MS) + MICRO_W'(us_acc_r);
      o_sub_r   <= us_acc_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_total_seconds    = o_sec_r;
  assign out_milli_ticks      = o_mil_r;
  assign out_micro_part       = o_micro_r;
  assign out_sub_milli_micros = o_sub_r;

`ifndef SYNTHESIS
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (us_acc_r < US_PER_MS) && (ms_acc_r < US_PER_MS))
    else $error("sub-second accumulator out of range");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_MIC0))
    else $error("accepted request did not start the sub-second step");

  a_milli_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEC) |-> (mc_r <= US_PER_MS))
    else $error("milli carry out of range");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done state");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid_r && !out_ready |=> (state_r == ST_DONE))
    else $error("finished result left before output was free");
`endif

endmodule
